// ===== rtl/core/sha256_pkg.sv =====
// shared types, constants and functions for the sha-256 byte stream hasher
package sha256_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    logic   valid;
    item_t  item;
  } queue_head_t;

  localparam logic [255:0] InitialH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/core/sha256_byte_stream_hasher_core.sv =====
// top level of the sha-256 byte stream hasher
// each byte is written into the block register; a full block starts compression
// end of message: one or two padding blocks, then 8 digest words
// bytes are taken only while idle; during compression by the single round unit they wait in the input queue
// rst is synchronous: chaining value set to initial hash, counts cleared
module sha256_byte_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sha256_pkg::item_t       in_item;
  sha256_pkg::queue_head_t head;
  logic                    take;

  assign in_item.data_byte = data_byte;
  assign in_item.byte_valid = byte_valid;
  assign in_item.end_of_message = end_of_message;

  sha256_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .in_item(in_item), .head(head), .take(take)
  );

  sha256_back u_back (
    .clk(clk), .rst(rst), .head(head), .take(take), .empty(empty), .pop(pop),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

`ifndef ASSERT_OFF
  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last_word == (word_index == 3'd7)))
    else $error("last word flag mismatch");
  a_step: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_word) |=> (!empty && word_index == $past(word_index) + 3'd1))
    else $error("digest word order broken");
  a_take: assert property (@(posedge clk) disable iff (rst)
    take |-> head.valid)
    else $error("take from empty queue");
`endif

endmodule

// ===== rtl/core/sha256_front.sv =====
// input queue between the byte port and the compression engine
module sha256_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  sha256_pkg::item_t     in_item,
  output sha256_pkg::queue_head_t head,
  input  logic                  take
);

  sha256_pkg::item_t mem [sha256_pkg::QDepth];
  logic [sha256_pkg::QAw-1:0] wr_ptr;
  logic [sha256_pkg::QAw-1:0] rd_ptr;
  logic [sha256_pkg::QAw:0]   count;
  logic do_push;
  logic do_pop;

  assign full = (count == (sha256_pkg::QAw+1)'(sha256_pkg::QDepth));
  assign do_push = push && !full;
  assign do_pop = take && (count != '0);
  assign head.valid = (count != '0);
  assign head.item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (sha256_pkg::QAw+1)'(do_push) - (sha256_pkg::QAw+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= in_item;
  end

endmodule

// ===== rtl/core/sha256_back.sv =====
// block assembly, padding, 64-round compression and digest output
module sha256_back (
  input  logic                    clk,
  input  logic                    rst,
  input  sha256_pkg::queue_head_t head,
  output logic                    take,
  output logic                    empty,
  input  logic                    pop,
  output logic [31:0]             digest_word,
  output logic [2:0]              word_index,
  output logic                    last_word
);

  sha256_pkg::back_state_t state, state_next;
  logic [511:0] blk;
  logic [5:0]   fill_count;
  logic [63:0]  message_bits;
  logic [255:0] hv;
  logic [255:0] v;
  logic [511:0] w;
  logic [5:0]   rnd;
  logic         final_blk;
  logic         need_second;
  logic         pending_end;
  logic [2:0]   out_idx;

  logic [511:0] blk_byte;
  logic [511:0] pad_blk;
  logic [31:0]  a, b, c, d, e, f, g, h, wr, t1, t2, s0, s1, wn;
  logic [255:0] hsum;

  assign {a, b, c, d, e, f, g, h} = v;
  assign wr = w[511:480];
  assign t1 = h + (sha256_pkg::ror(e, 6) ^ sha256_pkg::ror(e, 11) ^ sha256_pkg::ror(e, 25))
            + ((e & f) ^ (~e & g)) + sha256_pkg::round_k(rnd) + wr;
  assign t2 = (sha256_pkg::ror(a, 2) ^ sha256_pkg::ror(a, 13) ^ sha256_pkg::ror(a, 22))
            + ((a & b) ^ (a & c) ^ (b & c));
  assign s0 = sha256_pkg::ror(w[479:448], 7) ^ sha256_pkg::ror(w[479:448], 18)
            ^ (w[479:448] >> 3);
  assign s1 = sha256_pkg::ror(w[63:32], 17) ^ sha256_pkg::ror(w[63:32], 19)
            ^ (w[63:32] >> 10);
  assign wn = s1 + w[223:192] + s0 + w[511:480];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hsum[i*32 +: 32] = hv[i*32 +: 32] + v[i*32 +: 32];
    end
  end

  // byte slot written at fill position, big-endian order
  always_comb begin
    blk_byte = blk;
    blk_byte[(63 - fill_count)*8 +: 8] = head.item.data_byte;
  end

  // zeros after fill, pad byte at fill, length at tail only when it fits; a second block is zeros and length
  always_comb begin
    pad_blk = blk;
    for (int i = 0; i < 64; i++) begin
      if (need_second) begin
        pad_blk[(63-i)*8 +: 8] = (i < 56) ? 8'h00 : message_bits[(63-i)*8 +: 8];
      end else if (i == fill_count) begin
        pad_blk[(63-i)*8 +: 8] = sha256_pkg::PadByte;
      end else if (i > fill_count) begin
        pad_blk[(63-i)*8 +: 8] = (i < 56 || fill_count >= 6'd56) ? 8'h00
                                 : message_bits[(63-i)*8 +: 8];
      end
    end
  end

  assign empty = (state != sha256_pkg::ST_OUT);
  assign digest_word = hv[(7 - out_idx)*32 +: 32];
  assign word_index = out_idx;
  assign last_word = (out_idx == 3'd7);

  always_comb begin
    state_next = state;
    take = 1'b0;
    case (state)
      sha256_pkg::ST_IDLE: begin
        if (head.valid) begin
          take = 1'b1;
          if (head.item.byte_valid && fill_count == 6'd63) begin
            state_next = sha256_pkg::ST_ROUND;
          end else if (head.item.end_of_message) begin
            state_next = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: state_next = sha256_pkg::ST_ROUND;
      sha256_pkg::ST_ROUND: if (rnd == 6'd63) state_next = sha256_pkg::ST_ADD;
      sha256_pkg::ST_ADD: begin
        if (final_blk) state_next = sha256_pkg::ST_OUT;
        else if (need_second || pending_end) state_next = sha256_pkg::ST_PAD;
        else state_next = sha256_pkg::ST_IDLE;
      end
      sha256_pkg::ST_OUT: if (pop && out_idx == 3'd7) state_next = sha256_pkg::ST_IDLE;
      default: state_next = sha256_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_IDLE;
      fill_count <= '0;
      message_bits <= '0;
      hv <= sha256_pkg::InitialH;
      rnd <= '0;
      final_blk <= 1'b0;
      need_second <= 1'b0;
      pending_end <= 1'b0;
      out_idx <= '0;
    end else begin
      state <= state_next;
      case (state)
        sha256_pkg::ST_IDLE: begin
          if (head.valid) begin
            if (head.item.byte_valid) begin
              blk <= blk_byte;
              fill_count <= fill_count + 6'd1;
              message_bits <= message_bits + 64'd8;
              if (fill_count == 6'd63) begin
                w <= blk_byte;
                v <= hv;
                rnd <= '0;
                final_blk <= 1'b0;
                need_second <= 1'b0;
                pending_end <= head.item.end_of_message;
              end
            end
          end
        end
        sha256_pkg::ST_PAD: begin
          w <= pad_blk;
          v <= hv;
          rnd <= '0;
          final_blk <= need_second || (fill_count < 6'd56);
          need_second <= !need_second && (fill_count >= 6'd56);
          fill_count <= '0;
        end
        sha256_pkg::ST_ROUND: begin
          v <= {t1 + t2, a, b, c, d + t1, e, f, g};
          w <= {w[479:0], wn};
          rnd <= rnd + 6'd1;
        end
        sha256_pkg::ST_ADD: begin
          hv <= hsum;
          if (pending_end) begin
            pending_end <= 1'b0;
            need_second <= 1'b0;
          end
          out_idx <= '0;
        end
        sha256_pkg::ST_OUT: begin
          if (pop) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              hv <= sha256_pkg::InitialH;
              fill_count <= '0;
              message_bits <= '0;
              need_second <= 1'b0;
              final_blk <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== test/sha256_byte_stream_hasher_core_tb.sv =====
// self-checking testbench for the sha-256 byte stream hasher core
module sha256_byte_stream_hasher_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_exp_t;

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = '0;
  logic        byte_valid = 1'b0;
  logic        end_of_message = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  logic [7:0]  msg_block [64];
  int          block_fill;
  logic [63:0] length_bits;
  logic [31:0] hash_state [8];
  digest_exp_t pending_digest [$];

  int          errors = 0;
  int          words_sent = 0;
  int          burst_left = 0;
  bit          no_gaps = 1'b0;
  int          hold_requests = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          pop_mode = 0;
  int          mode_left = 0;
  longint      cycles = 0;

  sha256_byte_stream_hasher_core u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .data_byte(data_byte), .byte_valid(byte_valid), .end_of_message(end_of_message),
    .empty(empty), .pop(pop),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_hash();
    block_fill = 0;
    length_bits = '0;
    for (int i = 0; i < 8; i++) hash_state[i] = sha256_pkg::InitialH[255 - 32 * i -: 32];
  endtask

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int r = 0; r < 16; r++)
      w[r] = {msg_block[4 * r], msg_block[4 * r + 1], msg_block[4 * r + 2], msg_block[4 * r + 3]};
    for (int r = 16; r < 64; r++)
      w[r] = (rotr(w[r - 2], 17) ^ rotr(w[r - 2], 19) ^ (w[r - 2] >> 10)) + w[r - 7]
           + (rotr(w[r - 15], 7) ^ rotr(w[r - 15], 18) ^ (w[r - 15] >> 3)) + w[r - 16];
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endtask

  task automatic hash_byte(input logic [7:0] b, input logic v, input logic e);
    int pos;
    digest_exp_t d;
    if (v) begin
      msg_block[block_fill] = b;
      block_fill++;
      length_bits = length_bits + 64'd8;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (e) begin
      pos = block_fill;
      msg_block[pos++] = sha256_pkg::PadByte;
      if (pos > 56) begin
        while (pos < 64) msg_block[pos++] = 8'h00;
        compress_block();
        pos = 0;
      end
      while (pos < 56) msg_block[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[56 + i] = length_bits[63 - 8 * i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        d.word = hash_state[i];
        d.index = 3'(i);
        d.last = (i == 7);
        pending_digest.push_back(d);
      end
      restart_hash();
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // sender: one word per call, bursts with random gaps
  task automatic send_word(input logic [7:0] b, input logic v, input logic e);
    int gap;
    push <= 1'b1;
    data_byte <= b;
    byte_valid <= v;
    end_of_message <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    hash_byte(b, v, e);
    words_sent++;
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending_digest.size() != 0) @(posedge clk);
  endtask

  task automatic send_message(input int len, input bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, (i == len - 1) && !noisy);
    end
    if (len == 0 || noisy) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_word(8'hff, 1'b0, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h55, 1'b0, 1'b0);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'haa, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_requests++;
    no_gaps = 1'b1;
    for (int i = 0; i < 16; i++) send_word(8'($urandom), 1'($urandom), 1'b1);
    no_gaps = 1'b0;
    wait_drained();
  endtask

  task automatic test_block_edges();
    int edges [5] = '{55, 56, 63, 64, 65};
    foreach (edges[i]) send_message(edges[i], 1'b0);
    wait_drained();
  endtask

  task automatic test_random();
    int len, pick;
    while (words_sent < 410) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) len = $urandom_range(0, 12);
      else if (pick < 9) len = $urandom_range(50, 70);
      else len = $urandom_range(0, 140);
      if (len > 410 - words_sent) len = 410 - words_sent;
      send_message(len, $urandom_range(0, 3) == 0);
    end
    push <= 1'b0;
  endtask

  // receiver: checks every popped word, stalls on its own pattern
  always @(posedge clk) begin
    digest_exp_t d;
    cycles <= cycles + 1;
    if (!rst && pop && !empty) begin
      if (pending_digest.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", digest_word));
      end else begin
        d = pending_digest.pop_front();
        if (digest_word !== d.word)
          report_mismatch($sformatf("digest word %h, want %h", digest_word, d.word));
        if (word_index !== d.index)
          report_mismatch($sformatf("word index %0d, want %0d", word_index, d.index));
        if (last_word !== d.last)
          report_mismatch($sformatf("last flag %b, want %b", last_word, d.last));
      end
    end
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = 800;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 150);
      pop_mode = $urandom_range(0, 2);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        default: pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (cycles > 600000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    restart_hash();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_block_edges();
    test_random();
    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sha256_pkg.sv
rtl/core/sha256_front.sv
rtl/core/sha256_back.sv
rtl/core/sha256_byte_stream_hasher_core.sv
test/sha256_byte_stream_hasher_core_tb.sv
